### design/assert_macros.svh
// assertion macros used by the checker file c39e_checker.sv
// no dependencies; the including scope provides i_clk and i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/c39e_pkg.sv
// shared types, constants and symbol lookup functions of the code 39 encoder
// no dependencies
package c39e_pkg;

    // symbol set facts
    localparam logic [5:0] GUARD_SYM     = 6'd39;
    localparam logic [6:0] NUM_CHECK     = 7'd43;
    localparam logic [8:0] GUARD_PATTERN = 9'h052;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam int         CFG_INDEX_W         = 1;
    localparam logic [0:0] CFG_CHECKSUM_ENABLE = 1'd0;
    localparam logic [0:0] CFG_EXTENDED_MODE   = 1'd1;

    // job slot positions, emitted from low to high
    localparam int SLOT_W     = 6;
    localparam int SLOT_START = 0;
    localparam int SLOT_DATA0 = 1;
    localparam int SLOT_DATA1 = 2;
    localparam int SLOT_CHECK = 3;
    localparam int SLOT_STOP  = 4;
    localparam int SLOT_ERROR = 5;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [8:0] width_pattern;
        logic [5:0] symbol_index;
        logic       is_guard;
        logic       last_symbol;
        logic       bad_char;
    } t_out_word;

    typedef struct packed {
        logic checksum_enable;
        logic extended_mode;
    } t_cfg;

    // one classified character: which symbols to emit and their indexes
    typedef struct packed {
        logic [SLOT_W-1:0] slots;
        logic [5:0]        sym0;
        logic [5:0]        sym1;
        logic [5:0]        chk_sym;
    } t_job;

    typedef struct packed {
        logic       ok;
        logic [5:0] idx;
    } t_sym;

    typedef struct packed {
        logic       two;
        logic [5:0] s0;
        logic [5:0] s1;
    } t_ext;

    // symbol index of a byte after case folding
    function automatic t_sym sym_of(input logic [7:0] c);
        logic [7:0] cf;
        t_sym       r;
        cf = c;
        r.ok = 1'b1;
        r.idx = 6'd0;
        if (c inside {[8'd97:8'd122]}) cf = c - 8'd32;
        if (cf inside {[8'd49:8'd57]}) r.idx = 6'(cf - 8'd49);
        else if (cf == 8'd48) r.idx = 6'd9;
        else if (cf inside {[8'd65:8'd90]}) r.idx = 6'(cf - 8'd55);
        else if (cf == 8'd45) r.idx = 6'd36;
        else if (cf == 8'd46) r.idx = 6'd37;
        else if (cf == 8'd32) r.idx = 6'd38;
        else if (cf == 8'd42) r.idx = 6'd39;
        else if (cf == 8'd36) r.idx = 6'd40;
        else if (cf == 8'd47) r.idx = 6'd41;
        else if (cf == 8'd43) r.idx = 6'd42;
        else if (cf == 8'd37) r.idx = 6'd43;
        else r.ok = 1'b0;
        return r;
    endfunction

    // full ascii map: shift symbol ($ / + %) then letter, or one plain symbol
    function automatic t_ext ext_map(input logic [6:0] c);
        t_ext r;
        r.two = 1'b1;
        r.s0 = 6'd43;
        r.s1 = 6'd0;
        if (c == 7'd0) begin
            r.s1 = 6'd30;
        end else if (c inside {[7'd1:7'd26]}) begin
            r.s0 = 6'd40;
            r.s1 = 6'(c + 7'd9);
        end else if (c inside {[7'd27:7'd31]}) begin
            r.s1 = 6'(c - 7'd17);
        end else if (c == 7'd32) begin
            r.two = 1'b0;
            r.s0 = 6'd38;
        end else if (c inside {[7'd33:7'd44]}) begin
            r.s0 = 6'd41;
            r.s1 = 6'(c - 7'd23);
        end else if (c == 7'd45) begin
            r.two = 1'b0;
            r.s0 = 6'd36;
        end else if (c == 7'd46) begin
            r.two = 1'b0;
            r.s0 = 6'd37;
        end else if (c == 7'd47) begin
            r.s0 = 6'd41;
            r.s1 = 6'd24;
        end else if (c == 7'd48) begin
            r.two = 1'b0;
            r.s0 = 6'd9;
        end else if (c inside {[7'd49:7'd57]}) begin
            r.two = 1'b0;
            r.s0 = 6'(c - 7'd49);
        end else if (c == 7'd58) begin
            r.s0 = 6'd41;
            r.s1 = 6'd35;
        end else if (c inside {[7'd59:7'd63]}) begin
            r.s1 = 6'(c - 7'd44);
        end else if (c == 7'd64) begin
            r.s1 = 6'd31;
        end else if (c inside {[7'd65:7'd90]}) begin
            r.two = 1'b0;
            r.s0 = 6'(c - 7'd55);
        end else if (c inside {[7'd91:7'd95]}) begin
            r.s1 = 6'(c - 7'd71);
        end else if (c == 7'd96) begin
            r.s1 = 6'd32;
        end else if (c inside {[7'd97:7'd122]}) begin
            r.s0 = 6'd42;
            r.s1 = 6'(c - 7'd87);
        end else begin
            r.s1 = 6'(c - 7'd98);
        end
        return r;
    endfunction

    // check value of a data symbol
    function automatic logic [5:0] check_of(input logic [5:0] s);
        logic [5:0] v;
        if (s < 6'd9) v = s + 6'd1;
        else if (s == 6'd9) v = 6'd0;
        else if (s < 6'd39) v = s;
        else v = s - 6'd1;
        return v;
    endfunction

    // symbol that carries a given check value
    function automatic logic [5:0] sym_of_check(input logic [5:0] v);
        logic [5:0] s;
        if (v == 6'd0) s = 6'd9;
        else if (v < 6'd10) s = v - 6'd1;
        else if (v < 6'd39) s = v;
        else s = v + 6'd1;
        return s;
    endfunction

    // mod 43 add of two values below 43
    function automatic logic [5:0] add_mod(input logic [5:0] a, input logic [5:0] b);
        logic [6:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= NUM_CHECK) sum = sum - NUM_CHECK;
        return sum[5:0];
    endfunction

    // wide bars for the units digit of the symbol index
    function automatic logic [4:0] bar_of(input logic [3:0] d);
        logic [4:0] b;
        case (d)
            4'd0:    b = 5'h11;
            4'd1:    b = 5'h12;
            4'd2:    b = 5'h03;
            4'd3:    b = 5'h14;
            4'd4:    b = 5'h05;
            4'd5:    b = 5'h06;
            4'd6:    b = 5'h18;
            4'd7:    b = 5'h09;
            4'd8:    b = 5'h0A;
            4'd9:    b = 5'h0C;
            default: b = 5'h00;
        endcase
        return b;
    endfunction

    // wide space for the tens digit, or for the four bar-less symbols
    function automatic logic [3:0] space_of(input logic special, input logic [1:0] k);
        logic [3:0] sp;
        case ({special, k})
            3'b000:  sp = 4'h2;
            3'b001:  sp = 4'h4;
            3'b010:  sp = 4'h8;
            3'b011:  sp = 4'h1;
            3'b100:  sp = 4'h7;
            3'b101:  sp = 4'hB;
            3'b110:  sp = 4'hD;
            3'b111:  sp = 4'hE;
            default: sp = 4'h0;
        endcase
        return sp;
    endfunction

    // nine-element pattern, bars on even bits and spaces on odd bits
    function automatic logic [8:0] pattern_of(input logic [5:0] s);
        logic [4:0] b;
        logic [3:0] sp;
        logic [5:0] dig;
        logic [1:0] dec;
        logic [8:0] p;
        b = 5'd0;
        p = 9'd0;
        dec = 2'd0;
        dig = s;
        if (s >= 6'd30) begin
            dec = 2'd3;
            dig = s - 6'd30;
        end else if (s >= 6'd20) begin
            dec = 2'd2;
            dig = s - 6'd20;
        end else if (s >= 6'd10) begin
            dec = 2'd1;
            dig = s - 6'd10;
        end
        if (s < 6'd40) begin
            b = bar_of(dig[3:0]);
            sp = space_of(1'b0, dec);
        end else begin
            sp = space_of(1'b1, s[1:0]);
        end
        for (int k = 0; k < 5; k++) p[2*k] = b[k];
        for (int k = 0; k < 4; k++) p[2*k+1] = sp[k];
        return p;
    endfunction

endpackage

### design/c39e_front.sv
// front end: classifies each accepted character into a job of symbols
// keeps the barcode state (started, check value, dropping); uses c39e_pkg
module c39e_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  c39e_pkg::t_in_word i_in,
    input  c39e_pkg::t_cfg    i_cfg,
    output logic              o_job_valid,
    output c39e_pkg::t_job    o_job
);

    logic       r_started;
    logic       r_dropping;
    logic [5:0] r_acc;
    logic       n_started;
    logic       n_dropping;
    logic [5:0] n_acc;

    c39e_pkg::t_sym sym_std;
    c39e_pkg::t_ext sym_ext;
    logic           ok;
    logic           two;
    logic [5:0]     s0;
    logic [5:0]     s1;
    logic [5:0]     acc1;
    logic [5:0]     acc2;
    logic           last;

    // symbol lookup in either mode
    always_comb begin
        sym_std = c39e_pkg::sym_of(i_in.char_code);
        sym_ext = c39e_pkg::ext_map(i_in.char_code[6:0]);
        if (i_cfg.extended_mode) begin
            ok = ~i_in.char_code[7];
            two = sym_ext.two;
            s0 = sym_ext.s0;
            s1 = sym_ext.s1;
        end else begin
            ok = sym_std.ok;
            two = 1'b0;
            s0 = sym_std.idx;
            s1 = 6'd0;
        end
        last = i_in.last_char;
    end

    // running check value, a data star adds nothing
    always_comb begin
        acc1 = (s0 == c39e_pkg::GUARD_SYM) ? r_acc
                                           : c39e_pkg::add_mod(r_acc, c39e_pkg::check_of(s0));
        acc2 = two ? c39e_pkg::add_mod(acc1, c39e_pkg::check_of(s1)) : acc1;
    end

    // job word
    always_comb begin
        o_job.slots = '0;
        o_job.slots[c39e_pkg::SLOT_START] = ok & ~r_started;
        o_job.slots[c39e_pkg::SLOT_DATA0] = ok;
        o_job.slots[c39e_pkg::SLOT_DATA1] = ok & two;
        o_job.slots[c39e_pkg::SLOT_CHECK] = ok & last & i_cfg.checksum_enable;
        o_job.slots[c39e_pkg::SLOT_STOP]  = ok & last;
        o_job.slots[c39e_pkg::SLOT_ERROR] = ~ok;
        o_job.sym0 = s0;
        o_job.sym1 = s1;
        o_job.chk_sym = c39e_pkg::sym_of_check(acc2);
        o_job_valid = i_accept & ~r_dropping;
    end

    // barcode state update
    always_comb begin
        n_started = r_started;
        n_dropping = r_dropping;
        n_acc = r_acc;
        if (i_accept) begin
            if (r_dropping) begin
                if (last) n_dropping = 1'b0;
            end else if (!ok) begin
                n_started = 1'b0;
                n_acc = 6'd0;
                n_dropping = ~last;
            end else if (last) begin
                n_started = 1'b0;
                n_acc = 6'd0;
            end else begin
                n_started = 1'b1;
                n_acc = acc2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_dropping <= 1'b0;
            r_acc <= 6'd0;
        end else begin
            r_started <= n_started;
            r_dropping <= n_dropping;
            r_acc <= n_acc;
        end
    end

endmodule

### design/c39e_queue.sv
// short job queue between the front and back ends
// depth set by parameter; uses c39e_pkg
module c39e_queue #(
    parameter int QUEUE_DEPTH = c39e_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  c39e_pkg::t_job i_wr_job,
    input  logic           i_rd_en,
    output logic           o_full,
    output logic           o_valid,
    output c39e_pkg::t_job o_rd_job
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    c39e_pkg::t_job r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           wr;
    logic           rd;

    assign o_full   = (r_count == DEPTH_C);
    assign o_valid  = (r_count != '0);
    assign o_rd_job = r_mem[r_rd_ptr];
    assign wr = i_wr_en & ~o_full;
    assign rd = i_rd_en & o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wr_ptr] <= i_wr_job;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (wr) r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            if (rd) r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            if (wr && !rd) r_count <= r_count + CW'(1);
            else if (rd && !wr) r_count <= r_count - CW'(1);
        end
    end

endmodule

### design/c39e_back.sv
// back end: walks the slots of the head job, one symbol word per cycle while
// the output register is empty or being taken; holds the output register; uses c39e_pkg
module c39e_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  c39e_pkg::t_job      i_job,
    output logic                o_job_pop,
    input  logic                i_out_pop,
    output logic                o_out_valid,
    output c39e_pkg::t_out_word o_out
);

    logic [c39e_pkg::SLOT_W-1:0] r_done;
    logic                        r_out_valid;
    c39e_pkg::t_out_word         r_out;

    logic [c39e_pkg::SLOT_W-1:0] pend;
    logic [c39e_pkg::SLOT_W-1:0] first;
    logic                        finishing;
    logic                        load;
    logic [5:0]                  sym;
    c39e_pkg::t_out_word         n_out;

    // pick the lowest pending slot
    always_comb begin
        pend = i_job.slots & ~r_done;
        first = pend & (~pend + c39e_pkg::SLOT_W'(1));
        finishing = ((pend & ~first) == '0);
        load = i_job_valid & (~r_out_valid | i_out_pop);
        o_job_pop = load & finishing;
    end

    // symbol word for the chosen slot
    always_comb begin
        if (first[c39e_pkg::SLOT_DATA0]) sym = i_job.sym0;
        else if (first[c39e_pkg::SLOT_DATA1]) sym = i_job.sym1;
        else if (first[c39e_pkg::SLOT_CHECK]) sym = i_job.chk_sym;
        else sym = c39e_pkg::GUARD_SYM;
        if (first[c39e_pkg::SLOT_ERROR]) begin
            n_out.width_pattern = 9'd0;
            n_out.symbol_index = 6'd0;
            n_out.is_guard = 1'b0;
            n_out.last_symbol = 1'b1;
            n_out.bad_char = 1'b1;
        end else begin
            n_out.width_pattern = c39e_pkg::pattern_of(sym);
            n_out.symbol_index = sym;
            n_out.is_guard = first[c39e_pkg::SLOT_START] | first[c39e_pkg::SLOT_STOP];
            n_out.last_symbol = first[c39e_pkg::SLOT_STOP];
            n_out.bad_char = 1'b0;
        end
    end

    // slot progress within the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (load) begin
            r_done <= finishing ? '0 : (r_done | first);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

endmodule

### design/code39_symbol_encoder.sv
// top level of the code 39 symbol encoder: config registers and wiring
// depends on c39e_pkg, c39e_front, c39e_queue, c39e_back
//
// Input side is a queue: drive i_in and raise push while full is low; one
// character word per accepted push, last_char set on the final character.
// Result side is a queue too: while empty is low o_out holds the oldest
// symbol word, and pop takes it. Each character gives one or two data
// symbols, the first of a barcode is preceded by the start guard, the last
// is followed by an optional mod-43 check symbol and the stop guard. A
// character that cannot be encoded gives a single error word and the rest
// of that barcode is discarded up to its last character.
// A character's job is written into the job queue, and its first word then
// goes into the output register. Throughput: one symbol word per cycle
// from the output register while pop keeps up; a character yields up to
// five words (none while dropped); the front takes one character per cycle
// while full is low, into a job queue that holds four jobs by default.
// When pop stays low, words wait in the output register and the job queue,
// and full rises once the queue is full. Configuration is written on the
// i_cfg channel, always ready, and applies from the next character.
// Reset empties the queue and output, sets checksum on and extended off.
module code39_symbol_encoder #(
    parameter int QUEUE_DEPTH = c39e_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  c39e_pkg::t_in_word                i_in,
    output logic                              empty,
    input  logic                              pop,
    output c39e_pkg::t_out_word               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [c39e_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic                              i_cfg_data
);

    c39e_pkg::t_cfg r_cfg;
    c39e_pkg::t_job front_job;
    c39e_pkg::t_job head_job;
    logic           front_job_valid;
    logic           head_valid;
    logic           head_pop;
    logic           out_valid;
    logic           accept;

    assign o_cfg_ready = 1'b1;
    assign accept = push & ~full;
    assign empty = ~out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.checksum_enable <= 1'b1;
            r_cfg.extended_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                c39e_pkg::CFG_CHECKSUM_ENABLE: r_cfg.checksum_enable <= i_cfg_data;
                c39e_pkg::CFG_EXTENDED_MODE:   r_cfg.extended_mode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    c39e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_job_valid (front_job_valid),
        .o_job       (front_job)
    );

    c39e_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (front_job_valid),
        .i_wr_job (front_job),
        .i_rd_en  (head_pop),
        .o_full   (full),
        .o_valid  (head_valid),
        .o_rd_job (head_job)
    );

    c39e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_job_pop   (head_pop),
        .i_out_pop   (pop & out_valid),
        .o_out_valid (out_valid),
        .o_out       (o_out)
    );

endmodule

### design/c39e_checker.sv
// port-level checks of the code 39 encoder, bound to the top level
// depends on assert_macros.svh and c39e_pkg
`include "assert_macros.svh"

module c39e_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                empty,
    input logic                pop,
    input c39e_pkg::t_out_word o_out
);

    // a waiting word holds until it is taken
    `ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(o_out))

    // guards are always the star symbol with its fixed pattern
    `ASSERT_NOW(a_guard, !empty && o_out.is_guard, o_out.symbol_index == c39e_pkg::GUARD_SYM && o_out.width_pattern == c39e_pkg::GUARD_PATTERN && !o_out.bad_char)

    // error word carries nothing but its flags
    `ASSERT_NOW(a_error, !empty && o_out.bad_char, o_out.last_symbol && o_out.width_pattern == 9'd0 && o_out.symbol_index == 6'd0)

    // a barcode ends only on the stop guard or an error word
    `ASSERT_NOW(a_end, !empty && o_out.last_symbol, o_out.is_guard || o_out.bad_char)

endmodule

bind code39_symbol_encoder c39e_checker u_checker (.*);
